// ===== sv/hslp_pkg.sv =====
`default_nettype none
package hslp_pkg;

  localparam int TABLE_SIZE_DEF = 1024;
  localparam int KEY_W          = 32;
  localparam int FUNC_W         = 2;
  localparam int MARK_W         = 2;
  localparam int MOD_STEP_BITS  = 4;
  localparam int MOD_CYCLES     = KEY_W / MOD_STEP_BITS;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_SEARCH = 2'd2
  } func_t;

  typedef enum logic [MARK_W-1:0] {
    MK_EMPTY   = 2'd0,
    MK_USED    = 2'd1,
    MK_DELETED = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage
`default_nettype wire

// ===== sv/hslp_ram.sv =====
`default_nettype none
module hslp_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/hslp_queue.sv =====
`default_nettype none
module hslp_queue #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  valid
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    cnt;

  assign full  = (cnt == CW'(DEPTH));
  assign valid = (cnt != '0);
  assign dout  = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= din;
    end
  end

endmodule
`default_nettype wire

// ===== sv/hslp_front.sv =====
`default_nettype none
module hslp_front #(
  parameter int TABLE_SIZE = hslp_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            hold,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [hslp_pkg::FUNC_W-1:0]     in_func,
  input  wire logic [hslp_pkg::KEY_W-1:0]      in_key,
  output logic                                 q_push,
  input  wire logic                            q_full,
  output logic      [hslp_pkg::FUNC_W-1:0]     q_func,
  output logic      [hslp_pkg::KEY_W-1:0]      q_key,
  output logic      [$clog2(TABLE_SIZE)-1:0]   q_home
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int SW = $clog2(hslp_pkg::MOD_CYCLES);
  localparam logic [IW:0]   TSV       = (IW + 1)'(TABLE_SIZE);
  localparam logic [SW-1:0] LAST_STEP = SW'(hslp_pkg::MOD_CYCLES - 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                     state;
  logic [SW-1:0]               step;
  logic [hslp_pkg::KEY_W-1:0]  mag;
  logic [IW-1:0]               rem;
  logic [IW-1:0]               rem_next;
  logic [hslp_pkg::FUNC_W-1:0] func;
  logic [hslp_pkg::KEY_W-1:0]  key;

  // restoring remainder, MOD_STEP_BITS bits of the magnitude per cycle
  always_comb begin
    logic [IW:0]   t;
    logic [IW-1:0] r;
    r = rem;
    t = '0;
    for (int b = 0; b < hslp_pkg::MOD_STEP_BITS; b++) begin
      t = {r, mag[hslp_pkg::KEY_W-1-b]};
      if (t >= TSV) begin
        t = t - TSV;
      end
      r = t[IW-1:0];
    end
    rem_next = r;
  end

  assign in_ready = (state == F_IDLE) && !hold;
  assign q_push   = ((state == F_DIV) && (step == LAST_STEP) && !q_full) ||
                    ((state == F_PUSH) && !q_full);
  assign q_func   = func;
  assign q_key    = key;
  assign q_home   = (state == F_DIV) ? rem_next : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            state <= F_DIV;
          end
        end
        F_DIV: begin
          if (step == LAST_STEP) begin
            state <= q_full ? F_PUSH : F_IDLE;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid && in_ready) begin
      func <= in_func;
      key  <= in_key;
      mag  <= in_key[hslp_pkg::KEY_W-1] ? (hslp_pkg::KEY_W)'(0) - in_key : in_key;
      rem  <= '0;
      step <= '0;
    end else if (state == F_DIV) begin
      rem  <= rem_next;
      mag  <= mag << hslp_pkg::MOD_STEP_BITS;
      step <= step + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/hslp_back.sv =====
`default_nettype none
module hslp_back #(
  parameter int TABLE_SIZE = hslp_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire logic [hslp_pkg::FUNC_W-1:0]   q_func,
  input  wire logic [hslp_pkg::KEY_W-1:0]    q_key,
  input  wire logic [$clog2(TABLE_SIZE)-1:0] q_home,
  output logic                               q_pop,
  output logic                               clearing,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_success,
  output logic      [1:0]                    out_status
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int DW = hslp_pkg::MARK_W + hslp_pkg::KEY_W;
  localparam logic [IW-1:0] LAST = IW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_SIZE);

  typedef enum logic [3:0] {
    B_CLEAR = 4'b0001,
    B_IDLE  = 4'b0010,
    B_PROBE = 4'b0100,
    B_DONE  = 4'b1000
  } bstate_t;

  bstate_t                    state;
  logic [IW-1:0]              clr;
  logic [CW-1:0]              count;
  hslp_pkg::func_t            func;
  logic [hslp_pkg::KEY_W-1:0] key;
  logic [IW-1:0]              cur;
  logic [IW-1:0]              cur_next;
  logic [IW-1:0]              n;
  logic [IW-1:0]              tgt;
  logic                       tgt_vld;

  logic                       wr_en;
  logic [IW-1:0]              wr_addr;
  hslp_pkg::mark_t            wr_mark;
  logic                       res_ok;
  hslp_pkg::status_t          res_st;

  logic                       ram_we;
  logic [IW-1:0]              ram_waddr;
  logic [DW-1:0]              ram_wdata;
  logic [IW-1:0]              ram_raddr;
  logic [DW-1:0]              ram_rdata;

  logic                       rd_empty;
  logic                       rd_hit;
  logic                       rd_used;
  logic                       last;
  logic                       stop;
  logic                       d_we;
  logic [IW-1:0]              d_addr;
  hslp_pkg::mark_t            d_mark;
  logic                       d_ok;
  hslp_pkg::status_t          d_st;
  logic [IW-1:0]              ins_tgt;
  logic                       out_free;
  logic                       commit;

  assign clearing = (state == B_CLEAR);
  assign q_pop    = (state == B_IDLE) && q_valid;
  assign out_free = !out_valid || out_ready;
  assign commit   = (state == B_DONE) && out_free;
  assign cur_next = (cur == LAST) ? '0 : cur + 1'b1;

  // next slot is read ahead while the current one is judged
  assign ram_raddr = (state == B_IDLE) ? q_home : cur_next;
  assign ram_we    = clearing || (commit && wr_en);
  assign ram_waddr = clearing ? clr : wr_addr;
  assign ram_wdata = clearing ? {hslp_pkg::MK_EMPTY, (hslp_pkg::KEY_W)'(0)} : {wr_mark, key};

  hslp_ram #(
    .WIDTH (DW),
    .DEPTH (TABLE_SIZE)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_empty = (ram_rdata[DW-1 -: hslp_pkg::MARK_W] == hslp_pkg::MK_EMPTY);
  assign rd_used  = (ram_rdata[DW-1 -: hslp_pkg::MARK_W] == hslp_pkg::MK_USED);
  assign rd_hit   = rd_used && (ram_rdata[hslp_pkg::KEY_W-1:0] == key);
  assign last     = (n == LAST);
  assign ins_tgt  = tgt_vld ? tgt : cur;

  always_comb begin
    stop   = 1'b0;
    d_we   = 1'b0;
    d_addr = cur;
    d_mark = hslp_pkg::MK_USED;
    d_ok   = 1'b0;
    d_st   = hslp_pkg::ST_NOT_FOUND;
    case (func)
      hslp_pkg::FN_INSERT: begin
        if (rd_empty) begin
          stop   = 1'b1;
          d_we   = 1'b1;
          d_addr = ins_tgt;
          d_ok   = 1'b1;
          d_st   = hslp_pkg::ST_DONE;
        end else if (rd_hit) begin
          stop = 1'b1;
          d_st = hslp_pkg::ST_PRESENT;
        end else if (last) begin
          stop = 1'b1;
          if (tgt_vld || !rd_used) begin
            d_we   = 1'b1;
            d_addr = ins_tgt;
            d_ok   = 1'b1;
            d_st   = hslp_pkg::ST_DONE;
          end else begin
            d_st = hslp_pkg::ST_FULL;
          end
        end
      end
      hslp_pkg::FN_REMOVE: begin
        if (rd_hit) begin
          stop   = 1'b1;
          d_we   = 1'b1;
          d_mark = hslp_pkg::MK_DELETED;
          d_ok   = 1'b1;
          d_st   = hslp_pkg::ST_DONE;
        end else if (rd_empty || last) begin
          stop = 1'b1;
        end
      end
      hslp_pkg::FN_SEARCH: begin
        if (rd_hit) begin
          stop = 1'b1;
          d_ok = 1'b1;
          d_st = hslp_pkg::ST_DONE;
        end else if (rd_empty || last) begin
          stop = 1'b1;
        end
      end
      default: stop = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == LAST) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_valid) begin
            case (hslp_pkg::func_t'(q_func))
              hslp_pkg::FN_INSERT: state <= (count >= FULL) ? B_DONE : B_PROBE;
              hslp_pkg::FN_REMOVE: state <= B_PROBE;
              hslp_pkg::FN_SEARCH: state <= B_PROBE;
              default:             state <= B_DONE;
            endcase
          end
        end
        B_PROBE: begin
          if (stop) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= B_IDLE;
            if (wr_en && wr_mark == hslp_pkg::MK_USED) begin
              count <= count + 1'b1;
            end else if (wr_en && count != '0) begin
              count <= count - 1'b1;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        func    <= hslp_pkg::func_t'(q_func);
        key     <= q_key;
        cur     <= q_home;
        n       <= '0;
        tgt_vld <= 1'b0;
        wr_en   <= 1'b0;
        res_ok  <= 1'b0;
        res_st  <= (hslp_pkg::func_t'(q_func) == hslp_pkg::FN_INSERT) ?
                   hslp_pkg::ST_FULL : hslp_pkg::ST_NOT_FOUND;
      end
      B_PROBE: begin
        if (stop) begin
          wr_en   <= d_we;
          wr_addr <= d_addr;
          wr_mark <= d_mark;
          res_ok  <= d_ok;
          res_st  <= d_st;
        end else begin
          cur <= cur_next;
          n   <= n + 1'b1;
          if (!rd_used && !tgt_vld) begin
            tgt     <= cur;
            tgt_vld <= 1'b1;
          end
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_success <= res_ok;
          out_status  <= res_st;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/hash_set_linear_probing.sv =====
// Flow: the front accepts a request and forms the home-slot remainder 4 key bits a cycle,
//   then the back starts the probe, judges one slot per cycle probed and commits.
// Overlap: the front remainder unit takes a new request while the slot RAM probe loop
//   (one read and one write port) works on an earlier one, through a 2-entry queue.
// Reset: synchronous; afterwards the slot RAM is swept to empty slot by slot, and
//   during the sweep s_axis_tready stays low.
`default_nettype none
module hash_set_linear_probing #(
  parameter int TABLE_SIZE = hslp_pkg::TABLE_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // key[31:0]
  input  wire logic [1:0]  s_axis_tuser,  // func[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [7:0]  m_axis_tdata   // success[0], status[2:1], zero[7:3]
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int QW = hslp_pkg::FUNC_W + hslp_pkg::KEY_W + IW;

  logic                        clearing;
  logic                        f_push;
  logic                        q_full;
  logic [hslp_pkg::FUNC_W-1:0] f_func;
  logic [hslp_pkg::KEY_W-1:0]  f_key;
  logic [IW-1:0]               f_home;
  logic [QW-1:0]               q_dout;
  logic                        q_valid;
  logic                        q_pop;
  logic                        success;
  logic [1:0]                  status;

  hslp_front #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .hold     (clearing),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_func  (s_axis_tuser),
    .in_key   (s_axis_tdata),
    .q_push   (f_push),
    .q_full   (q_full),
    .q_func   (f_func),
    .q_key    (f_key),
    .q_home   (f_home)
  );

  hslp_queue #(
    .WIDTH (QW),
    .DEPTH (hslp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   ({f_home, f_key, f_func}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid)
  );

  hslp_back #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_func      (q_dout[hslp_pkg::FUNC_W-1:0]),
    .q_key       (q_dout[hslp_pkg::FUNC_W +: hslp_pkg::KEY_W]),
    .q_home      (q_dout[QW-1 -: IW]),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_success (success),
    .out_status  (status)
  );

  assign m_axis_tdata = {5'b0, status, success};

endmodule
`default_nettype wire

// ===== sv/hslp_checker.sv =====
`default_nettype none
module hslp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [31:0] s_axis_tdata,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata
);

  logic       in_beat;
  logic       out_beat;
  logic [2:0] pend;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (in_beat && !out_beat) begin
      pend <= pend + 1'b1;
    end else if (out_beat && !in_beat) begin
      pend <= pend - 1'b1;
    end
  end

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("ready or result right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_beat |-> (pend != 3'd0) || in_beat)
    else $error("result beat without a request");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    pend <= 3'd5)
    else $error("too many requests in flight");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[0] == (m_axis_tdata[2:1] == hslp_pkg::ST_DONE)) &&
      (m_axis_tdata[7:3] == 5'd0))
    else $error("success and status disagree");

endmodule

bind hash_set_linear_probing hslp_checker u_chk (.*);
`default_nettype wire

// ===== tb/sv/tb_hash_set_linear_probing.sv =====
`timescale 1ns / 1ps
module tb_hash_set_linear_probing;

  localparam int TBL = hslp_pkg::TABLE_SIZE_DEF;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
  } req_t;

  typedef struct packed {
    logic              success;
    hslp_pkg::status_t status;
  } answer_t;

  typedef struct packed {
    req_t    req;
    answer_t ans;
  } pending_answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  hash_set_linear_probing #(.TABLE_SIZE(TBL)) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  // shadow of the slot store
  logic [31:0]     slot_key_sh [TBL];
  hslp_pkg::mark_t slot_state [TBL];
  int unsigned     used_cnt;

  req_t            req_q[$];
  pending_answer_t answer_q[$];

  int  mismatch_cnt;
  int  n_pushed;
  int  n_accepted;
  int  n_by_func [4];
  int  st_seen [4];
  int  cyc;
  bit  calm;
  bit  beat_taken;
  int  gap_left;
  int  stall_left;
  req_t nxt_req;

  function automatic answer_t probe_table(logic [1:0] fn, logic [31:0] k);
    logic [31:0] mag;
    int unsigned idx;
    int unsigned hit;
    int unsigned target;
    bit          dup;
    answer_t     a;
    a.success = 1'b0;
    a.status  = hslp_pkg::ST_NOT_FOUND;
    mag = k[31] ? (32'd0 - k) : k;
    idx = mag % TBL;
    case (fn)
      hslp_pkg::FN_INSERT: begin
        if (used_cnt >= TBL) begin
          a.status = hslp_pkg::ST_FULL;
        end else begin
          target = TBL;
          dup = 1'b0;
          for (int n = 0; n < TBL; n++) begin
            if (slot_state[idx] == hslp_pkg::MK_EMPTY) begin
              if (target == TBL) target = idx;
              break;
            end
            if (slot_state[idx] == hslp_pkg::MK_USED) begin
              if (slot_key_sh[idx] == k) begin
                dup = 1'b1;
                break;
              end
            end else if (target == TBL) begin
              target = idx;
            end
            idx = (idx + 1) % TBL;
          end
          if (dup) begin
            a.status = hslp_pkg::ST_PRESENT;
          end else if (target < TBL) begin
            slot_key_sh[target] = k;
            slot_state[target] = hslp_pkg::MK_USED;
            used_cnt++;
            a.success = 1'b1;
            a.status = hslp_pkg::ST_DONE;
          end else begin
            a.status = hslp_pkg::ST_FULL;
          end
        end
      end
      hslp_pkg::FN_REMOVE, hslp_pkg::FN_SEARCH: begin
        hit = TBL;
        for (int n = 0; n < TBL; n++) begin
          if (slot_state[idx] == hslp_pkg::MK_EMPTY) break;
          if (slot_state[idx] == hslp_pkg::MK_USED && slot_key_sh[idx] == k) begin
            hit = idx;
            break;
          end
          idx = (idx + 1) % TBL;
        end
        if (hit < TBL) begin
          if (fn == hslp_pkg::FN_REMOVE) begin
            slot_state[hit] = hslp_pkg::MK_DELETED;
            if (used_cnt > 0) used_cnt--;
          end
          a.success = 1'b1;
          a.status = hslp_pkg::ST_DONE;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [31:0] pool_key();
    int r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 12) return $urandom;
    if (r < 16) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    // small cluster of home slots around the wrap point
    v = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(TBL - 8, TBL - 1);
    v = v + TBL * $urandom_range(0, 3);
    if ($urandom_range(0, 1)) v = 32'd0 - v;
    return v;
  endfunction

  function automatic logic [1:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return hslp_pkg::FN_INSERT;
    if (r < 70) return hslp_pkg::FN_REMOVE;
    if (r < 95) return hslp_pkg::FN_SEARCH;
    return FN_UNUSED;
  endfunction

  task automatic add_req(logic [1:0] fn, logic [31:0] k);
    req_t r;
    r.func = fn;
    r.key = k;
    req_q.push_back(r);
    n_pushed++;
  endtask

  task automatic wait_drain();
    do begin
      @(posedge clk);
      #1;
    end while (n_accepted != n_pushed || answer_q.size() != 0);
  endtask

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 40)
      $display("%0t: %s", $time, msg);
  endtask

  // accept and check at the rising edge
  always @(posedge clk) begin
    pending_answer_t e;
    cyc++;
    calm = ((cyc / 2000) % 5) == 1;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        st_seen[m_axis_tdata[2:1]]++;
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat %b", m_axis_tdata));
        end else begin
          e = answer_q.pop_front();
          if (m_axis_tdata[0] !== e.ans.success)
            report_mismatch($sformatf(
              "success mismatch func=%0d key=%h got=%b want success=%b status=%0d",
              e.req.func, e.req.key, m_axis_tdata, e.ans.success, e.ans.status));
          if (m_axis_tdata[2:1] !== e.ans.status)
            report_mismatch($sformatf(
              "status mismatch func=%0d key=%h got=%b want success=%b status=%0d",
              e.req.func, e.req.key, m_axis_tdata, e.ans.success, e.ans.status));
          if (m_axis_tdata[7:3] !== 5'd0)
            report_mismatch($sformatf(
              "pad mismatch func=%0d key=%h got=%b",
              e.req.func, e.req.key, m_axis_tdata));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        e.req.func = s_axis_tuser;
        e.req.key = s_axis_tdata;
        e.ans = probe_table(s_axis_tuser, s_axis_tdata);
        answer_q.push_back(e);
        n_by_func[s_axis_tuser]++;
        n_accepted++;
        beat_taken = 1'b1;
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !beat_taken) begin
    end else begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (req_q.size() > 0) begin
        nxt_req = req_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= nxt_req.key;
        s_axis_tuser <= nxt_req.func;
        gap_left = calm ? 0 : idle_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) stall_left = idle_len();
    end
  end

  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [31:0] k;
    int r;
    for (int i = 0; i < TBL; i++) begin
      slot_state[i] = hslp_pkg::MK_EMPTY;
      slot_key_sh[i] = '0;
    end
    used_cnt = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table: collisions, wrap, tombstones, extremes
    add_req(hslp_pkg::FN_INSERT, 32'd0);
    add_req(hslp_pkg::FN_INSERT, 32'd0);
    add_req(hslp_pkg::FN_INSERT, 32'h8000_0000);
    add_req(hslp_pkg::FN_INSERT, 32'h7FFF_FFFF);
    add_req(hslp_pkg::FN_INSERT, 32'hFFFF_FFFF);
    add_req(hslp_pkg::FN_INSERT, 32'd2047);
    add_req(hslp_pkg::FN_SEARCH, 32'd2047);
    add_req(hslp_pkg::FN_SEARCH, 32'd0 - 32'd2047);
    add_req(hslp_pkg::FN_REMOVE, 32'h8000_0000);
    add_req(hslp_pkg::FN_SEARCH, 32'd2047);
    add_req(hslp_pkg::FN_REMOVE, 32'h8000_0000);
    add_req(hslp_pkg::FN_INSERT, 32'd1024);
    add_req(hslp_pkg::FN_SEARCH, 32'd1024);
    add_req(hslp_pkg::FN_REMOVE, 32'd0);
    add_req(hslp_pkg::FN_REMOVE, 32'd0);
    add_req(FN_UNUSED, 32'd2047);
    add_req(FN_UNUSED, 32'hFFFF_FFFF);
    add_req(hslp_pkg::FN_SEARCH, 32'd5);
    add_req(hslp_pkg::FN_INSERT, 32'd5);
    add_req(hslp_pkg::FN_INSERT, 32'd0 - 32'd5);
    add_req(hslp_pkg::FN_SEARCH, 32'd0 - 32'd5);
    add_req(hslp_pkg::FN_REMOVE, 32'd5);
    add_req(hslp_pkg::FN_SEARCH, 32'd0 - 32'd5);
    add_req(hslp_pkg::FN_INSERT, 32'h5555_5555);
    add_req(hslp_pkg::FN_INSERT, 32'hAAAA_AAAA);

    // mixed traffic on a small colliding key pool
    for (int i = 0; i < 120; i++) add_req(pick_func(), pool_key());
    wait_drain();

    // clear every live key, leaving tombstones, then fill the table
    for (int i = 0; i < TBL; i++)
      if (slot_state[i] == hslp_pkg::MK_USED) add_req(hslp_pkg::FN_REMOVE, slot_key_sh[i]);
    wait_drain();
    for (int i = 0; i < TBL; i++) add_req(hslp_pkg::FN_INSERT, i);
    wait_drain();

    // full table
    add_req(hslp_pkg::FN_INSERT, 32'd5);
    add_req(hslp_pkg::FN_INSERT, 32'd4096);
    add_req(hslp_pkg::FN_SEARCH, 32'd1023);
    add_req(hslp_pkg::FN_SEARCH, 32'd0 - 32'd7);
    add_req(hslp_pkg::FN_SEARCH, 32'h7FFF_FFFF);
    add_req(hslp_pkg::FN_REMOVE, 32'd700);
    add_req(hslp_pkg::FN_REMOVE, 32'd700);
    add_req(hslp_pkg::FN_INSERT, 32'd1724);
    add_req(hslp_pkg::FN_INSERT, 32'd1724);
    add_req(hslp_pkg::FN_REMOVE, 32'd3);
    add_req(hslp_pkg::FN_REMOVE, 32'd9);
    add_req(hslp_pkg::FN_INSERT, 32'd0 - 32'd9);
    for (int i = 0; i < 80; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) k = $urandom_range(0, TBL - 1);
      else if (r < 75) k = $urandom_range(0, TBL - 1) + TBL;
      else k = $urandom;
      add_req(pick_func(), k);
    end
    wait_drain();
    repeat (100) @(posedge clk);

    $display("requests: %0d insert, %0d remove, %0d search, %0d unused op",
             n_by_func[hslp_pkg::FN_INSERT], n_by_func[hslp_pkg::FN_REMOVE],
             n_by_func[hslp_pkg::FN_SEARCH], n_by_func[FN_UNUSED]);
    $display("answers: %0d done, %0d present, %0d full, %0d not found",
             st_seen[hslp_pkg::ST_DONE], st_seen[hslp_pkg::ST_PRESENT],
             st_seen[hslp_pkg::ST_FULL], st_seen[hslp_pkg::ST_NOT_FOUND]);
    if (mismatch_cnt == 0 && answer_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
